>>> hdl/max_tracking_stack_assert.svh
// Assertion macros for the max tracking stack
`ifndef MAX_TRACKING_STACK_ASSERT_SVH
`define MAX_TRACKING_STACK_ASSERT_SVH

// same-cycle implication
`define MTS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("max_tracking_stack: check failed");

// next-cycle implication
`define MTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("max_tracking_stack: check failed");

`endif

>>> hdl/mts_pkg.sv
`default_nettype none

package mts_pkg;

  localparam int unsigned DEPTH_DEFAULT = 64;
  localparam int unsigned WIDTH_DEFAULT = 32;

  typedef logic [1:0] mts_action_t;
  typedef logic [1:0] mts_status_t;

  localparam mts_action_t ACT_PUSH  = 2'd0;
  localparam mts_action_t ACT_POP   = 2'd1;
  localparam mts_action_t ACT_QUERY = 2'd2;

  localparam mts_status_t STAT_OK    = 2'd0;
  localparam mts_status_t STAT_EMPTY = 2'd1;
  localparam mts_status_t STAT_FULL  = 2'd2;

  typedef struct packed {
    logic        accept;
    logic        push;
    logic        pop;
    logic        load_top;
    logic        load_out;
    mts_status_t status;
  } mts_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } mts_stat_t;

endpackage

`default_nettype wire

>>> hdl/mts_ctrl.sv
`default_nettype none

module mts_ctrl
  import mts_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire mts_action_t action_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  input  wire mts_stat_t   stat_i,
  output mts_cmd_t         cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;
  logic   slot_free;
  mts_status_t query_status;

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign slot_free    = !out_valid_q || !out_stall_i;
  assign query_status = stat_i.empty ? STAT_EMPTY : STAT_OK;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_EMIT;
          case (action_i)
            ACT_PUSH: begin
              if (stat_i.full) begin
                cmd_o.status = STAT_FULL;
              end else begin
                cmd_o.push = 1'b1;
              end
            end
            ACT_POP: begin
              if (stat_i.empty) begin
                cmd_o.status = STAT_EMPTY;
              end else begin
                cmd_o.pop = 1'b1;
                state_d   = S_READ;
              end
            end
            ACT_QUERY: cmd_o.status = query_status;
            default:   cmd_o.status = query_status;
          endcase
        end
      end
      S_READ: begin
        cmd_o.load_top = 1'b1;
        state_d        = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/mts_datapath.sv
`default_nettype none

module mts_datapath
  import mts_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEFAULT,
  parameter int unsigned WIDTH = WIDTH_DEFAULT,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned DW = $clog2(DEPTH + 1)
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic signed [WIDTH-1:0] value_i,
  input  wire mts_cmd_t                cmd_i,
  output mts_stat_t                    stat_o,
  output mts_status_t                  status_o,
  output logic signed [WIDTH-1:0]      top_value_o,
  output logic signed [WIDTH-1:0]      max_value_o,
  output logic [DW-1:0]                depth_o,
  output logic                         is_empty_o
);

  logic [2*WIDTH-1:0] mem [DEPTH];
  logic [2*WIDTH-1:0] rdata_q;

  logic [DW-1:0]           sp_q;
  logic signed [WIDTH-1:0] top_val_q, top_max_q;
  logic signed [WIDTH-1:0] push_max;
  logic [AW-1:0]           wr_addr, rd_addr;
  logic [DW-1:0]           rd_ptr;
  mts_status_t             status_q;

  assign stat_o.empty = (sp_q == '0);
  assign stat_o.full  = (sp_q == DW'(DEPTH));

  // top cache holds entry sp-1, so its max is the running max below a push
  assign push_max = (!stat_o.empty && !(value_i > top_max_q)) ? top_max_q : value_i;
  assign wr_addr  = sp_q[AW-1:0];
  assign rd_ptr   = sp_q - DW'(1) - DW'(1);
  assign rd_addr  = rd_ptr[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[wr_addr] <= {value_i, push_max};
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q <= '0;
    end else if (cmd_i.push) begin
      sp_q <= sp_q + DW'(1);
    end else if (cmd_i.pop) begin
      sp_q <= sp_q - DW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      top_val_q <= value_i;
      top_max_q <= push_max;
    end else if (cmd_i.load_top) begin
      top_val_q <= rdata_q[2*WIDTH-1:WIDTH];
      top_max_q <= rdata_q[WIDTH-1:0];
    end
    if (cmd_i.accept) begin
      status_q <= cmd_i.status;
    end
    if (cmd_i.load_out) begin
      status_o    <= status_q;
      top_value_o <= stat_o.empty ? '0 : top_val_q;
      max_value_o <= stat_o.empty ? '0 : top_max_q;
      depth_o     <= sp_q;
      is_empty_o  <= stat_o.empty;
    end
  end

endmodule

`default_nettype wire

>>> hdl/max_tracking_stack.sv
`default_nettype none

// Stack of signed values that reports its running maximum with every transaction.
// Each input transaction (push, pop or query) yields one result: status, top value,
// maximum, depth and empty flag as they stand afterwards. A push, query or refused pop
// passes S_EMIT before its result is loaded into the output register, a successful pop
// S_READ and then S_EMIT, the extra state being the registered read of the entry below
// from the single stack memory; S_EMIT waits while the output is stalled. A new transaction
// is taken once the previous result has been loaded into the output register, so
// transactions never overlap. The memory needs no clearing after reset.

module max_tracking_stack
  import mts_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEFAULT,
  parameter int unsigned WIDTH = WIDTH_DEFAULT,
  localparam int unsigned DW = $clog2(DEPTH + 1)
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [1:0]              action_i,
  input  wire logic signed [WIDTH-1:0] value_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic [1:0]                   status_o,
  output logic signed [WIDTH-1:0]      top_value_o,
  output logic signed [WIDTH-1:0]      max_value_o,
  output logic [DW-1:0]                depth_o,
  output logic                         is_empty_o
);

  mts_cmd_t  cmd;
  mts_stat_t stat;

  mts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  mts_datapath #(
    .DEPTH (DEPTH),
    .WIDTH (WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (value_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .status_o    (status_o),
    .top_value_o (top_value_o),
    .max_value_o (max_value_o),
    .depth_o     (depth_o),
    .is_empty_o  (is_empty_o)
  );

`include "max_tracking_stack_assert.svh"

  `MTS_ASSERT_NOW(a_empty_zero, out_valid_o && is_empty_o, top_value_o == '0 && max_value_o == '0)
  `MTS_ASSERT_NOW(a_max_ge_top, out_valid_o && !is_empty_o, max_value_o >= top_value_o)
  `MTS_ASSERT_NOW(a_full_depth, out_valid_o && status_o == STAT_FULL, depth_o == DW'(DEPTH))
  `MTS_ASSERT_NOW(a_err_empty, out_valid_o && status_o == STAT_EMPTY, is_empty_o)
  `MTS_ASSERT_NEXT(a_accept_busy, in_valid_i && !in_stall_o, in_stall_o)

endmodule

`default_nettype wire
